### design/ssp_pkg.sv
`timescale 1ns / 1ps

package ssp_pkg;

  localparam int CAPACITY = 32;
  localparam int DW       = 32;
  localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW       = $clog2(CAPACITY + 1);

  typedef logic [AW-1:0] idx_t;
  typedef logic [LW-1:0] len_t;

  localparam logic [1:0] KIND_FRONT  = 2'd0;
  localparam logic [1:0] KIND_BACK   = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SHIFT,
    ST_PRIME,
    ST_LIST
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic idle;
    logic exec;
    logic shift;
    logic prime;
    logic list;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic start_shift;
    logic shift_done;
    logic list_done;
  } sts_t;

  // physical slot of logical offset off from the front, off at most CAPACITY
  function automatic idx_t wrap_add(idx_t base, len_t off);
    logic [LW:0] sum;
    sum = (LW+1)'(base) + (LW+1)'(off);
    if (sum >= (LW+1)'(CAPACITY)) begin
      sum = sum - (LW+1)'(CAPACITY);
    end
    return sum[AW-1:0];
  endfunction

endpackage

### design/ssp_cmd_if.sv
`timescale 1ns / 1ps

interface ssp_cmd_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [31:0] value;
  logic signed [15:0] position;

  modport source (output valid, kind, value, position, input ready);
  modport sink (input valid, kind, value, position, output ready);
endinterface

### design/ssp_res_if.sv
`timescale 1ns / 1ps

interface ssp_res_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  logic               is_last;
  logic               list_empty;
  logic               insert_dropped;

  modport source (output valid, element, is_last, list_empty, insert_dropped, input ready);
  modport sink (input valid, element, is_last, list_empty, insert_dropped, output ready);
endinterface

### design/ssp_ram.sv
`timescale 1ns / 1ps

module ssp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/ssp_ctrl.sv
`timescale 1ns / 1ps

module ssp_ctrl import ssp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    unique case (state)
      ST_IDLE: begin
        ctl.idle = 1'b1;
        if (sts.in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        ctl.exec   = 1'b1;
        state_next = sts.start_shift ? ST_SHIFT : ST_PRIME;
      end
      ST_SHIFT: begin
        ctl.shift = 1'b1;
        if (sts.shift_done) begin
          state_next = ST_PRIME;
        end
      end
      ST_PRIME: begin
        ctl.prime  = 1'b1;
        state_next = ST_LIST;
      end
      ST_LIST: begin
        ctl.list = 1'b1;
        if (sts.list_done) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### design/ssp_dpath.sv
`timescale 1ns / 1ps

module ssp_dpath import ssp_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ctl_t             ctl,
  output sts_t             sts,
  ssp_cmd_if.sink          cmd,
  ssp_res_if.source        res
);

  // ring pointer and fill level
  idx_t head;
  len_t len;

  // latched command
  logic [1:0]  cmd_kind;
  logic [31:0] cmd_value;
  logic [15:0] cmd_pos;
  logic        dropped;

  // logical index for shift and listing, and read-data-valid flag for shift
  len_t cnt;
  logic primed;

  // result register
  logic        out_valid;
  logic [31:0] out_element;
  logic        out_last;
  logic        out_empty;
  logic        out_drop;

  // ram port
  logic        we;
  idx_t        waddr;
  logic [31:0] wdata;
  idx_t        raddr;
  logic [31:0] rdata;

  logic        full;
  logic        is_ins;
  logic        pos_ok;
  logic        pos_front;
  logic        pos_tail;
  idx_t        head_m1;
  idx_t        head_p1;
  len_t        len_m1;
  len_t        len_p1;
  logic [LW:0] cnt_p1;
  logic [LW:0] cnt_p2;
  len_t        roff;
  logic        load;
  logic        last_hit;

  assign cmd.ready = ctl.idle;

  assign full      = (len == LW'(CAPACITY));
  assign is_ins    = (cmd_kind == KIND_FRONT) || (cmd_kind == KIND_BACK);
  assign pos_ok    = !cmd_pos[15] && (cmd_pos < 16'(len));
  assign len_m1    = len - LW'(1);
  assign len_p1    = len + LW'(1);
  assign pos_front = (cmd_pos == 16'd0);
  assign pos_tail  = (cmd_pos == 16'(len_m1));
  assign head_m1   = (head == idx_t'(0)) ? idx_t'(CAPACITY - 1) : head - idx_t'(1);
  assign head_p1   = (head == idx_t'(CAPACITY - 1)) ? idx_t'(0) : head + idx_t'(1);
  assign cnt_p1    = (LW+1)'(cnt) + (LW+1)'(1);
  assign cnt_p2    = (LW+1)'(cnt) + (LW+1)'(2);

  assign load     = ctl.list && (!out_valid || res.ready);
  assign last_hit = (cnt_p1 == (LW+1)'(len));

  assign sts.in_valid    = cmd.valid;
  assign sts.start_shift = ctl.exec && (cmd_kind == KIND_REMOVE) && pos_ok
                           && !pos_front && !pos_tail;
  assign sts.shift_done  = ctl.shift && primed && (cnt_p2 == (LW+1)'(len));
  assign sts.list_done   = load && ((len == '0) || last_hit);

  // read offset: next source in a shift, lookahead element in a listing
  always_comb begin
    roff = '0;
    if (ctl.shift) begin
      roff = primed ? cnt_p2[LW-1:0] : cnt_p1[LW-1:0];
    end else if (ctl.list) begin
      roff = load ? cnt_p1[LW-1:0] : cnt;
    end
  end

  assign raddr = wrap_add(head, roff);

  always_comb begin
    we    = 1'b0;
    waddr = wrap_add(head, cnt);
    wdata = rdata;
    if (ctl.exec) begin
      we    = is_ins && !full;
      waddr = (cmd_kind == KIND_FRONT) ? head_m1 : wrap_add(head, len);
      wdata = cmd_value;
    end else if (ctl.shift) begin
      we = primed;
    end
  end

  ssp_ram #(
    .WIDTH (DW),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (ctl.idle && cmd.valid) begin
      cmd_kind  <= cmd.kind;
      cmd_value <= cmd.value;
      cmd_pos   <= cmd.position;
    end
    if (ctl.exec) begin
      dropped <= is_ins && full;
      cnt     <= cmd_pos[LW-1:0];
    end else if (ctl.shift && primed) begin
      cnt <= cnt_p1[LW-1:0];
    end else if (ctl.prime) begin
      cnt <= '0;
    end else if (load) begin
      cnt <= cnt_p1[LW-1:0];
    end
    if (load) begin
      out_element <= (len == '0) ? '0 : rdata;
      out_last    <= (len == '0) || last_hit;
      out_empty   <= (len == '0);
      out_drop    <= dropped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      len       <= '0;
      primed    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ctl.exec) begin
        primed <= 1'b0;
        case (cmd_kind)
          KIND_FRONT: begin
            if (!full) begin
              head <= head_m1;
              len  <= len_p1;
            end
          end
          KIND_BACK: begin
            if (!full) begin
              len <= len_p1;
            end
          end
          KIND_REMOVE: begin
            if (pos_ok && pos_front) begin
              head <= head_p1;
              len  <= len_m1;
            end else if (pos_ok && pos_tail) begin
              len <= len_m1;
            end
          end
          default: begin
          end
        endcase
      end else if (ctl.shift) begin
        primed <= 1'b1;
        if (sts.shift_done) begin
          len <= len_m1;
        end
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign res.valid          = out_valid;
  assign res.element        = out_element;
  assign res.is_last        = out_last;
  assign res.list_empty     = out_empty;
  assign res.insert_dropped = out_drop;

endmodule

### design/sequence_store_push_delete.sv
`timescale 1ns / 1ps
// an item taken is followed by the update, a ram prime read and the listing of len results,
//   len being the length after the update, at least 1 result; no new item is taken until the
//   listing is done; a remove inside the list first moves the later slots down (one prime
//   read, then one ram write per moved slot, as the ram reads and writes one slot per cycle)
// reset: synchronous, clears the fill level, ring pointer and result valid; slot contents
//   stay undefined until written

module sequence_store_push_delete import ssp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  ssp_cmd_if.sink    cmd,
  ssp_res_if.source  res
);

  // the store is a ring in one ram: a front insert writes before the head and moves it, a back
  // insert writes past the tail, a remove at the front or the back moves no slots, and a remove
  // inside closes the gap by moving the later slots down

  ctl_t ctl;
  sts_t sts;

  // sequencer: idle, update, shift, prime read, stream listing
  ssp_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  // ring storage, command latch and output register; the result register frees the
  // result side from the store so a listing item waits there while the next read runs
  ssp_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts),
    .cmd (cmd),
    .res (res)
  );

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ssp_pkg::*;

  // kind 3 is unused by the block: it changes nothing and just lists the sequence
  localparam logic [1:0] KIND_LIST = 2'd3;

  // how the random part leans while building a chunk of commands
  typedef enum {MODE_GROW, MODE_SHRINK, MODE_MIXED, MODE_NOISE} mix_mode_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [31:0] value;
    logic signed [15:0] position;
  } command_t;

  typedef struct {
    logic signed [31:0] element;
    logic               is_last;
    logic               list_empty;
    logic               insert_dropped;
  } listing_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ssp_cmd_if cmd_ch ();
  ssp_res_if res_ch ();

  sequence_store_push_delete dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // commands waiting to be driven, filled up front by the stimulus block
  command_t           cmd_backlog[$];
  // shadow of the stored sequence, front first
  logic signed [31:0] shadow_seq[$];
  // listing results still owed by the block, oldest first
  listing_t           listing_q[$];
  int                 mismatch_count = 0;

  // length as the stimulus generator sees it, to aim removes inside the list
  int gen_len = 0;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // update the shadow sequence for one accepted command and queue its listing
  function automatic void apply_command(input command_t c);
    logic     dropped;
    listing_t r;
    dropped = 1'b0;
    case (c.kind)
      KIND_FRONT, KIND_BACK: begin
        if (shadow_seq.size() >= CAPACITY) begin
          dropped = 1'b1;
        end else if (c.kind == KIND_FRONT) begin
          shadow_seq.push_front(c.value);
        end else begin
          shadow_seq.push_back(c.value);
        end
      end
      KIND_REMOVE: begin
        // negative or past-the-end positions leave the list alone
        if (!c.position[15] && int'(c.position) < shadow_seq.size()) begin
          shadow_seq.delete(int'(c.position));
        end
      end
      default: ;
    endcase
    if (shadow_seq.size() == 0) begin
      r.element        = '0;
      r.is_last        = 1'b1;
      r.list_empty     = 1'b1;
      r.insert_dropped = dropped;
      listing_q.push_back(r);
    end else begin
      for (int i = 0; i < shadow_seq.size(); i++) begin
        r.element        = shadow_seq[i];
        r.is_last        = (i == shadow_seq.size() - 1);
        r.list_empty     = 1'b0;
        r.insert_dropped = dropped;
        listing_q.push_back(r);
      end
    end
  endfunction

  // queue one command and track the length it leaves behind
  function automatic void plan_cmd(input logic [1:0] kind, input logic [31:0] value,
                                   input logic [15:0] position);
    command_t c;
    c.kind     = kind;
    c.value    = value;
    c.position = position;
    cmd_backlog.push_back(c);
    if ((kind == KIND_FRONT || kind == KIND_BACK) && gen_len < CAPACITY) begin
      gen_len++;
    end else if (kind == KIND_REMOVE && !position[15] && int'(position) < gen_len) begin
      gen_len--;
    end
  endfunction

  function automatic void plan_random(input mix_mode_t mode);
    int          roll;
    logic [15:0] pos;
    logic [1:0]  ins_kind;
    roll     = $urandom_range(99, 0);
    ins_kind = $urandom_range(1, 0) ? KIND_BACK : KIND_FRONT;
    // a remove aimed inside the current list, when there is one
    pos = (gen_len > 0) ? 16'($urandom_range(gen_len - 1, 0)) : 16'($urandom());
    case (mode)
      MODE_GROW: begin
        if (roll < 85) plan_cmd(ins_kind, $urandom(), 16'($urandom()));
        else plan_cmd(KIND_REMOVE, $urandom(), pos);
      end
      MODE_SHRINK: begin
        if (roll < 85) plan_cmd(KIND_REMOVE, $urandom(), pos);
        else plan_cmd(ins_kind, $urandom(), 16'($urandom()));
      end
      MODE_MIXED: begin
        if (roll < 45) begin
          plan_cmd(ins_kind, $urandom(), 16'($urandom()));
        end else if (roll < 80) begin
          plan_cmd(KIND_REMOVE, $urandom(), pos);
        end else if (roll < 90) begin
          // just past the end
          plan_cmd(KIND_REMOVE, $urandom(), 16'(gen_len + $urandom_range(3, 0)));
        end else begin
          // negative position
          plan_cmd(KIND_REMOVE, $urandom(), 16'($urandom()) | 16'h8000);
        end
      end
      default: begin
        plan_cmd(2'($urandom_range(3, 0)), $urandom(), 16'($urandom()));
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus: a directed opening, then chunks of random commands
  // ---------------------------------------------------------------------------
  initial begin
    int        n_random;
    int        chunk;
    mix_mode_t mode;

    // empty store: remove and plain listing both give the empty result
    plan_cmd(KIND_REMOVE, 32'h0, 16'h0);
    plan_cmd(KIND_LIST, 32'h1234_5678, 16'h0001);
    // value extremes at both ends
    plan_cmd(KIND_FRONT, 32'h7fff_ffff, 16'h0);
    plan_cmd(KIND_FRONT, 32'h8000_0000, 16'hffff);
    plan_cmd(KIND_BACK, 32'hffff_ffff, 16'h8000);
    plan_cmd(KIND_BACK, 32'h0000_0000, 16'h7fff);
    plan_cmd(KIND_BACK, 32'h5555_5555, 16'h5555);
    plan_cmd(KIND_FRONT, 32'haaaa_aaaa, 16'haaaa);
    // removes that must be ignored: negative, far out, exactly at the length
    plan_cmd(KIND_REMOVE, 32'h0, 16'hffff);
    plan_cmd(KIND_REMOVE, 32'h0, 16'h8000);
    plan_cmd(KIND_REMOVE, 32'h0, 16'h7fff);
    plan_cmd(KIND_REMOVE, 32'h0, 16'(gen_len));
    // removes in the middle, at the front and at the back
    plan_cmd(KIND_REMOVE, 32'hffff_ffff, 16'd2);
    plan_cmd(KIND_REMOVE, 32'h0, 16'd0);
    plan_cmd(KIND_REMOVE, 32'h0, 16'(gen_len - 1));
    plan_cmd(KIND_LIST, $urandom(), 16'($urandom()));
    // drain down to empty, then remove from the empty store once more
    while (gen_len > 0) begin
      plan_cmd(KIND_REMOVE, 32'h0, 16'd0);
    end
    plan_cmd(KIND_REMOVE, 32'h0, 16'd0);
    plan_cmd(KIND_BACK, $urandom(), 16'hffff);

    // first random chunk fills the store past capacity so inserts get dropped
    n_random = 0;
    repeat (CAPACITY + 4) begin
      plan_cmd($urandom_range(1, 0) ? KIND_BACK : KIND_FRONT, $urandom(), 16'($urandom()));
      n_random++;
    end
    while (n_random < 120) begin
      mode  = mix_mode_t'($urandom_range(3, 0));
      chunk = $urandom_range(30, 5);
      repeat (chunk) begin
        plan_random(mode);
        n_random++;
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait for the backlog to drain and every listing to come back; sampled
    // between edges so the driver's updates have settled
    @(posedge clk);
    @(negedge clk);
    while (cmd_backlog.size() != 0 || cmd_ch.valid || listing_q.size() != 0) begin
      @(negedge clk);
    end
    // catch any stray result after the last listing
    repeat (40) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // command driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  int burst_left = 1;
  int gap_left   = 0;

  initial begin
    cmd_ch.valid    = 1'b0;
    cmd_ch.kind     = KIND_LIST;
    cmd_ch.value    = '0;
    cmd_ch.position = '0;
    res_ch.ready    = 1'b0;
  end

  always @(posedge clk) begin : drive_cmd
    command_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      // the predictor follows the block item by item as they are taken
      if (cmd_ch.valid && cmd_ch.ready) begin
        nxt.kind     = cmd_ch.kind;
        nxt.value    = cmd_ch.value;
        nxt.position = cmd_ch.position;
        apply_command(nxt);
      end
      if (cmd_ch.valid && !cmd_ch.ready) begin
        // item still waiting, hold it
      end else if (gap_left > 0) begin
        cmd_ch.valid <= 1'b0;
        gap_left     <= gap_left - 1;
      end else if (cmd_backlog.size() > 0) begin
        nxt = cmd_backlog.pop_front();
        cmd_ch.valid    <= 1'b1;
        cmd_ch.kind     <= nxt.kind;
        cmd_ch.value    <= nxt.value;
        cmd_ch.position <= nxt.position;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(12, 1);
          // a quarter of the bursts run straight into the next one
          gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result side: ready follows a rotating pattern, repicked every so often
  // ---------------------------------------------------------------------------
  logic [15:0] ready_pat = 16'hffff;
  int          pat_age   = 0;

  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ready_pat[0];
      if (pat_age == 0) begin
        // a third of the time no stalls at all; otherwise a random mask
        // with at least one ready slot
        ready_pat <= ($urandom_range(2, 0) == 0) ? 16'hffff :
                     (16'($urandom()) | (16'h1 << $urandom_range(15, 0)));
        pat_age   <= $urandom_range(200, 48);
      end else begin
        ready_pat <= {ready_pat[0], ready_pat[15:1]};
        pat_age   <= pat_age - 1;
      end
    end
  end

  // monitor: each taken result against the oldest owed listing entry
  always @(posedge clk) begin : watch_res
    listing_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (listing_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected result element=%0d", res_ch.element));
      end else begin
        want = listing_q.pop_front();
        if (res_ch.element !== want.element) begin
          flag_mismatch($sformatf("element got %0d want %0d", res_ch.element, want.element));
        end
        if (res_ch.is_last !== want.is_last) begin
          flag_mismatch($sformatf("is_last got %b want %b", res_ch.is_last, want.is_last));
        end
        if (res_ch.list_empty !== want.list_empty) begin
          flag_mismatch($sformatf("list_empty got %b want %b",
                                  res_ch.list_empty, want.list_empty));
        end
        if (res_ch.insert_dropped !== want.insert_dropped) begin
          flag_mismatch($sformatf("insert_dropped got %b want %b",
                                  res_ch.insert_dropped, want.insert_dropped));
        end
      end
    end
  end

endmodule
